[hdl/tfmc_pkg.sv]
// Types, constants and helper functions shared by the fan mode controller.
// No dependencies.
`timescale 1ns / 1ps

package tfmc_pkg;

   localparam int ADC_W   = 10;
   localparam int DUTY_W  = 10;
   localparam int SEG_W   = 7;
   localparam int BAR_W   = 32;
   localparam int TEMP_W  = 9;
   localparam int LEVEL_W = 3;

   localparam logic [ADC_W-1:0]  ADC_FULL   = 10'd1023;
   localparam logic [9:0]        TEMP_SCALE = 10'd500;

   localparam logic [TEMP_W-1:0] TEMP_LOW  = 9'd25;
   localparam logic [TEMP_W-1:0] TEMP_MID  = 9'd30;
   localparam logic [TEMP_W-1:0] TEMP_HIGH = 9'd35;

   localparam logic [DUTY_W-1:0] DUTY_COOL = 10'd900;
   localparam logic [DUTY_W-1:0] DUTY_WARM = 10'd600;
   localparam logic [DUTY_W-1:0] DUTY_HOT  = 10'd300;
   localparam logic [DUTY_W-1:0] DUTY_MAX  = 10'd100;

   localparam logic [SEG_W-1:0]  SEG_AUTO   = 7'h06;
   localparam logic [SEG_W-1:0]  SEG_MANUAL = 7'h5B;

   localparam logic [7:0]        BYTE_ON = 8'hFF;

   localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_2 = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;

   typedef logic [TEMP_W-1:0] temp_type;

   // Bar graph for one digit: d lowest LEDs lit, all eight from 8 up.
   function automatic logic [7:0] digit_bar(input logic [5:0] d);
      logic [7:0] bar;
      if (d >= 6'd8) begin
         bar = BYTE_ON;
      end else begin
         bar = (8'd1 << d[2:0]) - 8'd1;
      end
      return bar;
   endfunction

endpackage

[hdl/tfmc_if.sv]
// Valid/ready channel interfaces for the request and response words.
// Depends on tfmc_pkg.
`timescale 1ns / 1ps

interface tfmc_req_if import tfmc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             mode_button;
   logic             level_button;
   logic [ADC_W-1:0] adc_sample;

   modport source (output valid, output mode_button, output level_button,
                   output adc_sample, input ready);
   modport sink   (input valid, input mode_button, input level_button,
                   input adc_sample, output ready);
endinterface

interface tfmc_rsp_if import tfmc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] fan_duty;
   logic [SEG_W-1:0]  mode_segments;
   logic [BAR_W-1:0]  led_bar;
   logic              buzzer_on;
   logic [TEMP_W-1:0] temperature_c;
   logic              manual_mode;

   modport source (output valid, output fan_duty, output mode_segments,
                   output led_bar, output buzzer_on, output temperature_c,
                   output manual_mode, input ready);
   modport sink   (input valid, input fan_duty, input mode_segments,
                   input led_bar, input buzzer_on, input temperature_c,
                   input manual_mode, output ready);
endinterface

[hdl/temperature_fan_mode_controller.sv]
// Fan controller top level: two register stages, mode/level/blink state.
// Depends on tfmc_pkg and tfmc_if.
`timescale 1ns / 1ps
//
// Usage:
//   req_ch carries one control pass per word: two button flags and a
//   10-bit temperature converter sample. rsp_ch returns exactly one word
//   per request: fan duty, mode digit segments, 32 LED bar, buzzer,
//   temperature in Celsius and the current mode.
//   A word is taken on req_ch at an edge with valid and ready high. Its
//   response then passes through the input register and the result
//   register before it is valid on rsp_ch. The input stage scales the
//   sample to Celsius; the result stage applies the mode state and builds
//   the outputs. One word per cycle is sustained while rsp_ch is ready.
//   When rsp_ch stalls, the result register holds and the input register
//   fills; req_ch.ready then drops until rsp_ch takes a word.
//   Reset empties both stages and returns to auto mode, level 1, blink
//   phase 0.

module temperature_fan_mode_controller
   import tfmc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   tfmc_req_if.sink     req_ch,
   tfmc_rsp_if.source   rsp_ch
);

   // input stage
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_mode_ff;
   logic          s1_level_ff;
   temp_type      s1_temp_ff, s1_temp_in;

   // result stage
   logic              s2_valid_ff, s2_valid_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [SEG_W-1:0]  segs_ff, segs_in;
   logic [BAR_W-1:0]  bar_ff, bar_in;
   logic              buzz_ff, buzz_in;
   temp_type          temp_ff, temp_in;

   // control state
   logic               manual_ff, manual_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               blink_ff, blink_in;

   logic s2_take, s1_move, req_take;

   // scaling: floor(sample*500/1023)
   logic [18:0] scaled;
   logic [8:0]  q0;
   logic [10:0] rem;

   // digits
   logic [16:0] tens_mul;
   logic [5:0]  tens;
   logic [3:0]  units;
   logic [7:0]  lo_bar, hi_bar;
   logic        over_temp;

   assign s2_take  = !s2_valid_ff || rsp_ch.ready;
   assign s1_move  = s1_valid_ff && s2_take;
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s2_take;

   always_comb begin
      scaled = 19'(req_ch.adc_sample) * 19'(TEMP_SCALE);
      q0     = scaled[18:10];
      rem    = 11'(scaled[9:0]) + 11'(q0);
      if (rem >= 11'(ADC_FULL)) begin
         s1_temp_in = q0 + 9'd1;
      end else begin
         s1_temp_in = q0;
      end
   end

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !s1_move);
      s2_valid_in = s1_move || (s2_valid_ff && !rsp_ch.ready);
   end

   // state update and outputs for the word leaving the input stage
   always_comb begin
      manual_in = manual_ff;
      level_in  = level_ff;
      blink_in  = blink_ff;
      duty_in   = duty_ff;
      segs_in   = segs_ff;
      bar_in    = bar_ff;
      buzz_in   = buzz_ff;
      temp_in   = temp_ff;

      tens_mul  = 17'(s1_temp_ff) * 17'd205;
      tens      = tens_mul[16:11];
      units     = 4'(s1_temp_ff - 9'(tens) * 9'd10);
      over_temp = s1_temp_ff > TEMP_HIGH;
      lo_bar    = digit_bar(6'(units));
      hi_bar    = digit_bar(tens);

      if (s1_move) begin
         manual_in = manual_ff ^ s1_mode_ff;
         if (s1_level_ff && manual_in) begin
            level_in = (level_ff >= LEVEL_4) ? LEVEL_1 : level_ff + 3'd1;
         end
         buzz_in = 1'b0;
         temp_in = '0;
         if (!manual_in) begin
            segs_in = SEG_AUTO;
            temp_in = s1_temp_ff;
            if (s1_temp_ff <= TEMP_LOW) begin
               duty_in = DUTY_COOL;
            end else if (s1_temp_ff <= TEMP_MID) begin
               duty_in = DUTY_WARM;
            end else if (!over_temp) begin
               duty_in = DUTY_HOT;
            end else begin
               duty_in = DUTY_MAX;
            end
            if (over_temp) begin
               if (!blink_ff) begin
                  buzz_in = 1'b1;
                  lo_bar  = ~lo_bar;
                  hi_bar  = ~hi_bar;
               end
               blink_in = ~blink_ff;
            end
            bar_in = {8'h00, hi_bar, 8'h00, lo_bar};
         end else begin
            segs_in = SEG_MANUAL;
            case (level_in)
               LEVEL_1: begin
                  duty_in = DUTY_COOL;
                  bar_in  = 32'h0000_00FF;
               end
               LEVEL_2: begin
                  duty_in = DUTY_WARM;
                  bar_in  = 32'h0000_FFFF;
               end
               LEVEL_3: begin
                  duty_in = DUTY_HOT;
                  bar_in  = 32'h00FF_FFFF;
               end
               default: begin
                  duty_in = DUTY_MAX;
                  bar_in  = 32'hFFFF_FFFF;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         manual_ff   <= 1'b0;
         level_ff    <= LEVEL_1;
         blink_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         manual_ff   <= manual_in;
         level_ff    <= level_in;
         blink_ff    <= blink_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff  <= req_ch.mode_button;
         s1_level_ff <= req_ch.level_button;
         s1_temp_ff  <= s1_temp_in;
      end
      duty_ff <= duty_in;
      segs_ff <= segs_in;
      bar_ff  <= bar_in;
      buzz_ff <= buzz_in;
      temp_ff <= temp_in;
   end

   assign rsp_ch.valid         = s2_valid_ff;
   assign rsp_ch.fan_duty      = duty_ff;
   assign rsp_ch.mode_segments = segs_ff;
   assign rsp_ch.led_bar       = bar_ff;
   assign rsp_ch.buzzer_on     = buzz_ff;
   assign rsp_ch.temperature_c = temp_ff;
   assign rsp_ch.manual_mode   = manual_ff;

endmodule

[bench/tb_temperature_fan_mode_controller.sv]
// Self-checking bench for temperature_fan_mode_controller: directed and random
// control passes, scoreboard predictor of mode, level, blink and every response field.
// Depends on tfmc_pkg, tfmc_if and the controller RTL.
`timescale 1ns / 1ps

module tb_temperature_fan_mode_controller;
   import tfmc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 80;

   typedef struct {
      logic [DUTY_W-1:0] duty;
      logic [SEG_W-1:0]  segs;
      logic [BAR_W-1:0]  bar;
      logic              buzz;
      temp_type          celsius;
      logic              manual;
   } fan_word_type;

   class fan_scoreboard;
      bit                 manual_flag;
      logic [LEVEL_W-1:0] fan_level;
      bit                 blink_phase;
      fan_word_type       pending[$];
      int unsigned        errors;

      function new();
         manual_flag = 1'b0;
         fan_level   = LEVEL_1;
         blink_phase = 1'b0;
         errors      = 0;
      endfunction

      function logic [7:0] digit_leds(int unsigned d);
         if (d >= 8) begin
            return 8'hFF;
         end
         return 8'((1 << d) - 1);
      endfunction

      function void note_pass(bit mode_btn, bit level_btn, logic [ADC_W-1:0] sample);
         fan_word_type w;
         int unsigned  deg;
         logic [7:0]   lo, hi;
         if (mode_btn) begin
            manual_flag = !manual_flag;
         end
         if (level_btn && manual_flag) begin
            fan_level = (fan_level >= LEVEL_4) ? LEVEL_1 : fan_level + 3'd1;
         end
         w.buzz    = 1'b0;
         w.celsius = '0;
         w.manual  = manual_flag;
         if (!manual_flag) begin
            deg = (int'(sample) * 500) / 1023;
            if (deg <= 25) begin
               w.duty = 10'd900;
            end else if (deg <= 30) begin
               w.duty = 10'd600;
            end else if (deg <= 35) begin
               w.duty = 10'd300;
            end else begin
               w.duty = 10'd100;
            end
            w.segs    = 7'h06;
            w.celsius = temp_type'(deg);
            lo = digit_leds(deg % 10);
            hi = digit_leds(deg / 10);
            if (deg > 35) begin
               if (!blink_phase) begin
                  w.buzz = 1'b1;
                  lo = ~lo;
                  hi = ~hi;
               end
               blink_phase = !blink_phase;
            end
            w.bar = {8'h00, hi, 8'h00, lo};
         end else begin
            w.segs = 7'h5B;
            case (fan_level)
               LEVEL_1: begin
                  w.duty = 10'd900;
                  w.bar  = 32'h0000_00FF;
               end
               LEVEL_2: begin
                  w.duty = 10'd600;
                  w.bar  = 32'h0000_FFFF;
               end
               LEVEL_3: begin
                  w.duty = 10'd300;
                  w.bar  = 32'h00FF_FFFF;
               end
               default: begin
                  w.duty = 10'd100;
                  w.bar  = 32'hFFFF_FFFF;
               end
            endcase
         end
         pending.push_back(w);
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_word(fan_word_type got);
         fan_word_type exp_w;
         if (pending.size() == 0) begin
            report("response word with none outstanding");
            return;
         end
         exp_w = pending.pop_front();
         if (got.duty !== exp_w.duty)
            report($sformatf("fan_duty %0d, want %0d", got.duty, exp_w.duty));
         if (got.segs !== exp_w.segs)
            report($sformatf("mode_segments %h, want %h", got.segs, exp_w.segs));
         if (got.bar !== exp_w.bar)
            report($sformatf("led_bar %h, want %h", got.bar, exp_w.bar));
         if (got.buzz !== exp_w.buzz)
            report($sformatf("buzzer_on %b, want %b", got.buzz, exp_w.buzz));
         if (got.celsius !== exp_w.celsius)
            report($sformatf("temperature_c %0d, want %0d", got.celsius, exp_w.celsius));
         if (got.manual !== exp_w.manual)
            report($sformatf("manual_mode %b, want %b", got.manual, exp_w.manual));
      endtask
   endclass

   logic clock;
   logic reset;

   tfmc_req_if req_bus ();
   tfmc_rsp_if rsp_bus ();

   temperature_fan_mode_controller DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   fan_scoreboard board;
   int unsigned   send_idle;
   int unsigned   recv_idle;
   bit            hold_request;
   bit            hold_off;
   int unsigned   cycles;

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("temperature_fan_mode_controller regression: fail");
         $finish;
      end
   end

   // long receiver stall so the pipeline fills and req ready drops
   initial begin
      hold_off = 1'b0;
      wait (hold_request);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready = !hold_off && ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      fan_word_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.duty    = rsp_bus.fan_duty;
         got.segs    = rsp_bus.mode_segments;
         got.bar     = rsp_bus.led_bar;
         got.buzz    = rsp_bus.buzzer_on;
         got.celsius = rsp_bus.temperature_c;
         got.manual  = rsp_bus.manual_mode;
         board.check_word(got);
      end
   end

   task send_pass(bit mode_btn, bit level_btn, logic [ADC_W-1:0] sample);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.mode_button  = mode_btn;
      req_bus.level_button = level_btn;
      req_bus.adc_sample   = sample;
      do @(posedge clock); while (!req_bus.ready);
      board.note_pass(mode_btn, level_btn, sample);
   endtask

   task run_random(int unsigned count);
      int unsigned       pick;
      logic [ADC_W-1:0]  sample;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            sample = ADC_W'($urandom_range(90, 40));
         end else if (pick < 50) begin
            sample = ($urandom_range(1) != 0) ? 10'd1023 : 10'd0;
         end else begin
            sample = ADC_W'($urandom_range(1023));
         end
         send_pass($urandom_range(99) < 8, $urandom_range(99) < 35, sample);
      end
   endtask

   initial begin
      board                = new();
      cycles               = 0;
      hold_request         = 1'b0;
      send_idle            = 22;
      recv_idle            = 72;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.mode_button  = 1'b0;
      req_bus.level_button = 1'b0;
      req_bus.adc_sample   = '0;
      rsp_bus.ready        = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // thresholds either side of 25, 30 and 35 degrees, then full scale
      send_pass(1'b0, 1'b0, 10'd0);
      send_pass(1'b0, 1'b0, 10'd53);
      send_pass(1'b0, 1'b0, 10'd54);
      send_pass(1'b0, 1'b0, 10'd63);
      send_pass(1'b0, 1'b0, 10'd64);
      send_pass(1'b0, 1'b0, 10'd73);
      send_pass(1'b0, 1'b0, 10'd74);
      send_pass(1'b0, 1'b0, 10'd184);
      send_pass(1'b0, 1'b0, 10'd72);
      send_pass(1'b0, 1'b0, 10'd1023);
      send_pass(1'b0, 1'b1, 10'd1023);
      send_pass(1'b0, 1'b0, 10'd179);
      // manual mode: level steps 1..4 and wraps
      send_pass(1'b1, 1'b0, 10'd600);
      send_pass(1'b0, 1'b1, 10'd1023);
      send_pass(1'b0, 1'b1, 10'd0);
      send_pass(1'b0, 1'b1, 10'd341);
      send_pass(1'b0, 1'b1, 10'd682);
      send_pass(1'b0, 1'b0, 10'd1023);
      // mode and level on the same pass, both directions
      send_pass(1'b1, 1'b1, 10'd100);
      send_pass(1'b1, 1'b1, 10'd512);
      send_pass(1'b1, 1'b1, 10'd1023);
      send_pass(1'b1, 1'b0, 10'd75);
      send_pass(1'b0, 1'b0, 10'd0);

      run_random(380);
      send_idle = 72;
      recv_idle = 22;
      run_random(380);
      send_idle    = 0;
      recv_idle    = 0;
      hold_request = 1'b1;
      run_random(370);

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (board.errors == 0) begin
         $display("temperature_fan_mode_controller regression: pass");
      end else begin
         $display("temperature_fan_mode_controller regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/tfmc_pkg.sv
hdl/tfmc_if.sv
hdl/temperature_fan_mode_controller.sv
bench/tb_temperature_fan_mode_controller.sv
